// ----- rtl/core/windowed_rate_meter_assert.svh -----
// Assertion macros for the windowed rate meter
`ifndef WINDOWED_RATE_METER_ASSERT_SVH
`define WINDOWED_RATE_METER_ASSERT_SVH
// Assert that a condition implies a consequence on the same edge
`define WRM_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Assert that a condition implies a consequence on the next edge
`define WRM_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- rtl/core/wrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types and constants of the windowed rate meter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package wrm_pkg;
  localparam int unsigned SourcesDefault   = 8;
  localparam int unsigned RingDepthDefault = 1024;
  localparam int unsigned TW  = 48;
  localparam int unsigned WW  = 32;
  localparam int unsigned RW  = 64;
  localparam int unsigned IDW = 136;
  localparam int unsigned ODW = 72;

  typedef enum logic [0:0] {
    FUNC_PUSH  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUSH,
    ST_RD,
    ST_WALK,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    D_IDLE,
    D_MUL,
    D_RUN,
    D_DONE
  } div_state_e;

  typedef struct packed {
    logic          start;
    logic [TW-1:0] dc;
    logic [TW-1:0] dt;
  } div_req_t;

  typedef struct packed {
    logic          busy;
    logic          done;
    logic [RW-1:0] q;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/wrm_div.sv -----
// ----------------------------------------------------------------------------
// wrm_div
// Bit-serial divider: floor(dc * 65536000 / dt), saturated to 64 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wrm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wrm_pkg::div_req_t req_i,
  output wrm_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned TW = wrm_pkg::TW;
  localparam int unsigned RW = wrm_pkg::RW;

  wrm_pkg::div_state_e st_q, st_d;
  logic [6:0]    cnt_q, cnt_d;
  logic [RW-1:0] p_q, p_d;
  logic [RW-1:0] lo_q, lo_d;
  logic [TW:0]   r_q, r_d;
  logic [RW-1:0] q_q, q_d;
  logic [TW-1:0] dt_q, dt_d;
  logic [TW-1:0] dc_q, dc_d;
  logic [TW+1:0] rsh;
  logic          ge;

  assign rsh = {r_q, lo_q[RW-1]};
  assign ge  = rsh >= {2'b00, dt_q};

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    p_d   = p_q;
    lo_d  = lo_q;
    r_d   = r_q;
    q_d   = q_q;
    dt_d  = dt_q;
    dc_d  = dc_q;
    unique case (st_q)
      wrm_pkg::D_IDLE: begin
        if (req_i.start) begin
          dt_d = req_i.dt;
          dc_d = req_i.dc;
          st_d = wrm_pkg::D_MUL;
        end
      end
      wrm_pkg::D_MUL: begin
        p_d  = RW'({16'd0, dc_q} * 64'd64000);
        r_d  = {{(TW-9){1'b0}}, p_d[RW-1:54]};
        lo_d = {p_d[53:0], 10'd0};
        q_d  = '0;
        cnt_d = 7'd0;
        if ({{(TW-10){1'b0}}, p_d[RW-1:54]} >= dt_q) begin
          q_d  = '1;
          st_d = wrm_pkg::D_DONE;
        end else begin
          st_d = wrm_pkg::D_RUN;
        end
      end
      wrm_pkg::D_RUN: begin
        lo_d = {lo_q[RW-2:0], 1'b0};
        if (ge) begin
          r_d = (TW+1)'(rsh - {2'b00, dt_q});
          q_d = {q_q[RW-2:0], 1'b1};
        end else begin
          r_d = rsh[TW:0];
          q_d = {q_q[RW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) st_d = wrm_pkg::D_DONE;
      end
      wrm_pkg::D_DONE: st_d = wrm_pkg::D_IDLE;
      default: st_d = wrm_pkg::D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= wrm_pkg::D_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q  <= p_d;
    lo_q <= lo_d;
    r_q  <= r_d;
    q_q  <= q_d;
    dt_q <= dt_d;
    dc_q <= dc_d;
  end

  assign rsp_o.busy = st_q != wrm_pkg::D_IDLE;
  assign rsp_o.done = st_q == wrm_pkg::D_DONE;
  assign rsp_o.q    = q_q;
endmodule
`default_nettype wire

// ----- rtl/core/wrm_store.sv -----
// ----------------------------------------------------------------------------
// wrm_store
// Sample memory: count and time per slot, one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module wrm_store #(
  parameter int unsigned AW = 13
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic [wrm_pkg::TW-1:0]  wcount_i,
  input  wire logic [wrm_pkg::TW-1:0]  wtime_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic      [wrm_pkg::TW-1:0]  rcount_o,
  output logic      [wrm_pkg::TW-1:0]  rtime_o
);
  logic [wrm_pkg::TW-1:0] cnt_mem [2**AW];
  logic [wrm_pkg::TW-1:0] tim_mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      cnt_mem[waddr_i] <= wcount_i;
      tim_mem[waddr_i] <= wtime_i;
    end
    rcount_o <= cnt_mem[raddr_i];
    rtime_o  <= tim_mem[raddr_i];
  end
endmodule
`default_nettype wire

// ----- rtl/core/windowed_rate_meter.sv -----
// ----------------------------------------------------------------------------
// windowed_rate_meter
// Per-source sample rings with windowed rate query.
//
// channel  dir  fields
// s_axis   in   tuser: func; tdata: source, sample_count, time_ms, window_ms
// m_axis   out  tdata: rate_q16, rate_valid
//
// Push: accept, then write in ST_PUSH. Query: accept, ST_RD, a walk of up to
// RING_DEPTH-1 slots in ST_WALK, the serial divider in ST_DIV. One memory
// read port sets the walk rate of one slot a cycle. After reset a clearing
// pass zeroes the time store; no item is taken meanwhile. A stalled result
// holds in the output register; the next item is taken once it has gone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "windowed_rate_meter_assert.svh"
module windowed_rate_meter #(
  parameter int unsigned SOURCES    = wrm_pkg::SourcesDefault,
  parameter int unsigned RING_DEPTH = wrm_pkg::RingDepthDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // source[2:0], sample_count[50:3], time_ms[98:51], window_ms[130:99]
  input  wire logic [wrm_pkg::IDW-1:0]  s_axis_tdata,
  // func[0]
  input  wire logic                     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // rate_q16[63:0], rate_valid[64]
  output logic      [wrm_pkg::ODW-1:0]  m_axis_tdata
);
  localparam int unsigned TW  = wrm_pkg::TW;
  localparam int unsigned SW  = SOURCES > 1 ? $clog2(SOURCES) : 1;
  localparam int unsigned DW  = $clog2(RING_DEPTH);
  localparam int unsigned AW  = SW + DW;
  localparam int unsigned CW  = AW + 1;

  wrm_pkg::state_e st_q, st_d;
  logic [DW-1:0]   top_q [SOURCES];
  logic [CW-1:0]   clr_q, clr_d;
  logic [SW-1:0]   src_q, src_d;
  logic [TW-1:0]   cnt_q, cnt_d;
  logic [TW-1:0]   now_q, now_d;
  logic [31:0]     win_q, win_d;
  logic [DW-1:0]   slot_q, slot_d;
  logic [DW:0]     step_q, step_d;
  logic            hnew_q, hnew_d, hear_q, hear_d;
  logic [TW-1:0]   nt_q, nt_d, nc_q, nc_d, et_q, et_d, ec_q, ec_d;
  logic [63:0]     rate_q, rate_d;
  logic            rv_q, rv_d;
  logic            ov_q, ov_d;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [TW-1:0]   wcount, wtime, rcount, rtime;
  logic            top_we;
  logic [2:0]      in_src;
  logic            src_ok;
  wrm_pkg::div_req_t dreq;
  wrm_pkg::div_rsp_t drsp;

  assign in_src = s_axis_tdata[2:0];
  assign src_ok = 32'(in_src) < SOURCES;

  wrm_store #(.AW(AW)) u_store (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wcount_i (wcount),
    .wtime_i  (wtime),
    .raddr_i  (raddr),
    .rcount_o (rcount),
    .rtime_o  (rtime)
  );

  wrm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  always_comb begin
    st_d   = st_q;
    clr_d  = clr_q;
    src_d  = src_q;
    cnt_d  = cnt_q;
    now_d  = now_q;
    win_d  = win_q;
    slot_d = slot_q;
    step_d = step_q;
    hnew_d = hnew_q;
    hear_d = hear_q;
    nt_d   = nt_q;
    nc_d   = nc_q;
    et_d   = et_q;
    ec_d   = ec_q;
    rate_d = rate_q;
    rv_d   = rv_q;
    ov_d   = ov_q;
    we     = 1'b0;
    waddr  = {src_q, slot_q};
    wcount = cnt_q;
    wtime  = now_q;
    raddr  = {src_q, slot_q};
    top_we = 1'b0;
    dreq.start = 1'b0;
    dreq.dc    = TW'(nc_q - ec_q);
    dreq.dt    = TW'(nt_q - et_q);
    s_axis_tready = 1'b0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    unique case (st_q)
      wrm_pkg::ST_CLEAR: begin
        we     = 1'b1;
        waddr  = clr_q[AW-1:0];
        wtime  = '0;
        clr_d  = clr_q + CW'(1);
        if (clr_q == CW'(2**AW - 1)) st_d = wrm_pkg::ST_IDLE;
      end
      wrm_pkg::ST_IDLE: begin
        s_axis_tready = !ov_q;
        if (s_axis_tvalid && !ov_q) begin
          src_d  = SW'(in_src);
          cnt_d  = s_axis_tdata[50:3];
          now_d  = s_axis_tdata[98:51];
          win_d  = s_axis_tdata[130:99];
          slot_d = top_q[SW'(in_src)];
          hnew_d = 1'b0;
          hear_d = 1'b0;
          rate_d = '0;
          rv_d   = 1'b0;
          if (s_axis_tuser == wrm_pkg::FUNC_PUSH) begin
            st_d = src_ok ? wrm_pkg::ST_PUSH : wrm_pkg::ST_IDLE;
          end else if (!src_ok) begin
            ov_d = 1'b1;
          end else begin
            slot_d = DW'(top_q[SW'(in_src)] - DW'(1));
            step_d = (DW+1)'(1);
            st_d   = wrm_pkg::ST_RD;
          end
        end
      end
      wrm_pkg::ST_PUSH: begin
        we     = 1'b1;
        top_we = 1'b1;
        st_d   = wrm_pkg::ST_IDLE;
      end
      wrm_pkg::ST_RD: begin
        st_d = wrm_pkg::ST_WALK;
      end
      wrm_pkg::ST_WALK: begin
        if (rtime == '0) begin
          ov_d = 1'b1;
          st_d = wrm_pkg::ST_IDLE;
        end else begin
          if (!hnew_q) begin
            hnew_d = 1'b1;
            nt_d   = rtime;
            nc_d   = rcount;
          end
          if (rtime > now_q || TW'(now_q - rtime) > {16'd0, win_q}) begin
            if (hear_q && et_q != (hnew_q ? nt_q : rtime)) begin
              st_d = wrm_pkg::ST_DIV;
            end else begin
              ov_d = 1'b1;
              st_d = wrm_pkg::ST_IDLE;
            end
          end else begin
            hear_d = 1'b1;
            et_d   = rtime;
            ec_d   = rcount;
            if (step_q == (DW+1)'(RING_DEPTH - 1)) begin
              ov_d = 1'b1;
              st_d = wrm_pkg::ST_IDLE;
            end else begin
              step_d = step_q + (DW+1)'(1);
              slot_d = DW'(slot_q - DW'(1));
              raddr  = {src_q, DW'(slot_q - DW'(1))};
              st_d   = wrm_pkg::ST_WALK;
            end
          end
          if (st_d == wrm_pkg::ST_WALK) raddr = {src_q, DW'(slot_q - DW'(1))};
        end
      end
      wrm_pkg::ST_DIV: begin
        dreq.start = !drsp.busy;
        if (drsp.done) begin
          rate_d = drsp.q;
          rv_d   = 1'b1;
          ov_d   = 1'b1;
          st_d   = wrm_pkg::ST_IDLE;
        end
      end
      default: st_d = wrm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wrm_pkg::ST_CLEAR;
      clr_q <= '0;
      ov_q <= 1'b0;
      for (int i = 0; i < int'(SOURCES); i++) top_q[i] <= '0;
    end else begin
      st_q  <= st_d;
      clr_q <= clr_d;
      ov_q  <= ov_d;
      if (top_we) top_q[src_q] <= DW'(slot_q + DW'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    cnt_q  <= cnt_d;
    now_q  <= now_d;
    win_q  <= win_d;
    slot_q <= slot_d;
    step_q <= step_d;
    hnew_q <= hnew_d;
    hear_q <= hear_d;
    nt_q   <= nt_d;
    nc_q   <= nc_d;
    et_q   <= et_d;
    ec_q   <= ec_d;
    rate_q <= rate_d;
    rv_q   <= rv_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, rv_q, rate_q};

  `WRM_ASSERT_IMP(a_rdy_idle, clk_i, rst_ni, s_axis_tready, st_q == wrm_pkg::ST_IDLE && !ov_q, "ready outside idle")
  `WRM_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
  `WRM_ASSERT_IMP(a_inv_zero, clk_i, rst_ni, m_axis_tvalid && !m_axis_tdata[64], m_axis_tdata[63:0] == 64'd0, "invalid rate not zero")
  `WRM_ASSERT_IMP(a_div_idle, clk_i, rst_ni, st_q != wrm_pkg::ST_DIV, !drsp.busy, "divider busy outside division")
endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the windowed rate meter: a queue-fed stream driver
// sends push and query items, a scoreboard predicts each query's rate from
// its own copy of the sample rings, and a monitor checks every result item.
// ----------------------------------------------------------------------------
module tb_top;
  localparam int unsigned NSRC   = 8;
  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned LIMIT  = 6000000;

  typedef struct {
    wrm_pkg::func_e func;
    logic [2:0]  src;
    logic [47:0] cnt;
    logic [47:0] tm;
    logic [31:0] win;
    bit          drain;
    int unsigned idle_pct;
    int unsigned stall_pct;
  } req_t;

  typedef struct {
    logic [63:0] rate;
    logic        valid;
  } rate_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [wrm_pkg::IDW-1:0]  s_axis_tdata = '0;
  logic                     s_axis_tuser = 1'b0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b1;
  logic [wrm_pkg::ODW-1:0]  m_axis_tdata;

  req_t        pending_q[$];
  rate_t       rate_q[$];
  req_t        cur_req;
  bit          taken;
  int unsigned stall_pct = 0;
  int unsigned err_cnt = 0;
  int unsigned cyc;

  logic [47:0] count_mem [NSRC][DEPTH];
  logic [47:0] stamp_mem [NSRC][DEPTH];
  logic [9:0]  ring_head [NSRC];

  windowed_rate_meter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  task automatic rate_predict(input req_t r);
    logic [9:0]   slot;
    logic [47:0]  t, c, nt, nc, et, ec, dc, dt;
    logic [127:0] num, quo;
    bit           have_new, have_early, full;
    rate_t        res;
    have_new   = 0;
    have_early = 0;
    full       = 0;
    nt = '0; nc = '0; et = '0; ec = '0;
    if (r.func == wrm_pkg::FUNC_PUSH) begin
      count_mem[r.src][ring_head[r.src]] = r.cnt;
      stamp_mem[r.src][ring_head[r.src]] = r.tm;
      ring_head[r.src] = ring_head[r.src] + 10'd1;
      return;
    end
    for (int i = 1; i < DEPTH; i++) begin
      slot = ring_head[r.src] - 10'(i);
      t = stamp_mem[r.src][slot];
      c = count_mem[r.src][slot];
      if (t == 0) break;
      if (!have_new) begin
        have_new = 1;
        nt = t;
        nc = c;
      end
      if (t > r.tm || (r.tm - t) > {16'b0, r.win}) begin
        full = 1;
        break;
      end
      have_early = 1;
      et = t;
      ec = c;
    end
    res.rate  = '0;
    res.valid = 1'b0;
    if (full && have_early && nt != et) begin
      dt  = nt - et;
      dc  = nc - ec;
      num = {80'b0, dc} * 128'd65536000;
      quo = num / {80'b0, dt};
      res.rate  = (quo[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : quo[63:0];
      res.valid = 1'b1;
    end
    rate_q.insert(rate_q.size(), res);
  endtask

  function automatic req_t mk(wrm_pkg::func_e f, int unsigned s, logic [47:0] c,
                              logic [47:0] t, logic [31:0] w);
    req_t r;
    r.func = f; r.src = 3'(s); r.cnt = c; r.tm = t; r.win = w;
    r.drain = 0; r.idle_pct = 0; r.stall_pct = 0;
    return r;
  endfunction

  function automatic void queue_item(req_t r);
    pending_q.insert(pending_q.size(), r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taken <= 1'b0;
      cyc   <= 0;
      for (int i = 0; i < NSRC; i++) begin
        ring_head[i] = '0;
        for (int j = 0; j < DEPTH; j++) begin
          count_mem[i][j] = '0;
          stamp_mem[i][j] = '0;
        end
      end
    end else begin
      cyc   <= cyc + 1;
      taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) rate_predict(cur_req);
      if (m_axis_tvalid && m_axis_tready) begin
        if (rate_q.size() == 0) begin
          $error("unexpected result item: rate_q16 %h", m_axis_tdata[63:0]);
          err_cnt++;
        end else begin
          if (m_axis_tdata[63:0] !== rate_q[0].rate) begin
            $error("rate_q16 expected %h actual %h", rate_q[0].rate, m_axis_tdata[63:0]);
            err_cnt++;
          end
          if (m_axis_tdata[64] !== rate_q[0].valid) begin
            $error("rate_valid expected %b actual %b", rate_q[0].valid, m_axis_tdata[64]);
            err_cnt++;
          end
          void'(rate_q.pop_front());
        end
      end
      if (cyc > LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || taken) begin
        if (pending_q.size() != 0 && !(pending_q[0].drain && rate_q.size() != 0) &&
            $urandom_range(99) >= pending_q[0].idle_pct) begin
          cur_req   = pending_q.pop_front();
          stall_pct = cur_req.stall_pct;
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= cur_req.func;
          s_axis_tdata  <= {5'b0, cur_req.win, cur_req.tm, cur_req.cnt, cur_req.src};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    logic [47:0] src_time [NSRC];
    logic [47:0] src_cnt  [NSRC];
    req_t        r;
    int unsigned s, k, ph;
    for (int i = 0; i < NSRC; i++) begin
      src_time[i]  = 48'd1000;
      src_cnt[i]   = '0;
    end
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    #1 rst_ni = 1'b1;

    queue_item(mk(wrm_pkg::FUNC_QUERY, 0, '0, 48'd50, 32'd10));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 1, '0, 48'd1, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 1, '0, 48'd10, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 1, '1, 48'd11, '0));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 1, '0, 48'd11, 32'd1));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 2, 48'd5, 48'd100, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 2, 48'd105, 48'd200, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 2, 48'd205, 48'd300, '0));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 2, '1, 48'd300, 32'd150));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 2, '0, 48'd300, '1));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 2, '0, 48'd250, 32'd100));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 2, '0, 48'd300, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 2, 48'd7, '0, '1));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 2, '0, 48'd300, 32'd150));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 3, '0, 48'd2, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 3, 48'd3, '1 - 48'd1, '0));
    queue_item(mk(wrm_pkg::FUNC_PUSH, 3, '1, '1, '0));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 3, '0, '1, '0));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 3, '0, '1, 32'd1));
    queue_item(mk(wrm_pkg::FUNC_QUERY, 3, '0, '1, '1));

    for (int i = 0; i < 520; i++) begin
      ph = i / 130;
      s  = $urandom_range(NSRC - 1);
      k  = $urandom_range(99);
      if (k < 55) begin
        src_time[s] = src_time[s] + 48'($urandom_range(60, 1));
        src_cnt[s]  = src_cnt[s] + 48'($urandom_range(5000));
        r = mk(wrm_pkg::FUNC_PUSH, s, src_cnt[s], src_time[s], '0);
      end else if (k < 90) begin
        r = mk(wrm_pkg::FUNC_QUERY, s, 48'({$urandom, $urandom}),
               src_time[s] + 48'($urandom_range(30)), 32'($urandom_range(400)));
      end else begin
        r = mk(wrm_pkg::func_e'($urandom_range(1)), s, 48'({$urandom, $urandom}),
               48'({$urandom, $urandom}), $urandom);
        if (r.func == wrm_pkg::FUNC_PUSH && r.tm > src_time[s]) src_time[s] = r.tm;
      end
      r.drain     = (i % 130 == 0);
      r.idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 86 : 9) : 0;
      r.stall_pct = (ph == 2 || ph == 3) ? ((ph == 2) ? 86 : 9) : 0;
      queue_item(r);
    end

    wait (pending_q.size() == 0 && !s_axis_tvalid && rate_q.size() == 0);
    repeat (1200) @(posedge clk_i);
    if (err_cnt == 0 && rate_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
